// File: sv/assert_macros.svh
// Assertion macros used by the RTL of the sensor poller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define OTSP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle, outside reset.
`define OTSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/otsp_pkg.sv
// Types, constants and codes of the 1-Wire temperature sensor poller.
package otsp_pkg;

    typedef logic [15:0] ticks_t;
    typedef logic [2:0]  cfg_idx_t;
    typedef logic [1:0]  pres_code_t;
    typedef logic [1:0]  status_t;
    typedef logic [3:0]  seq_state_t;

    localparam logic [3:0] FAULT_LIMIT      = 4'd10;
    localparam logic [4:0] SCRATCHPAD_BYTES = 5'd9;

    localparam logic [7:0] CMD_SKIP    = 8'hCC;
    localparam logic [7:0] CMD_CONVERT = 8'h44;
    localparam logic [7:0] CMD_READ    = 8'hBE;

    // Configuration register indexes
    localparam cfg_idx_t REG_RESET_LOW      = 3'd0;
    localparam cfg_idx_t REG_PRESENCE_DELAY = 3'd1;
    localparam cfg_idx_t REG_PRESENCE_WIN   = 3'd2;
    localparam cfg_idx_t REG_PRESENCE_MAX   = 3'd3;
    localparam cfg_idx_t REG_SLOT_SHORT     = 3'd4;
    localparam cfg_idx_t REG_SLOT_LONG      = 3'd5;
    localparam cfg_idx_t REG_READ_LOW       = 3'd6;
    localparam cfg_idx_t REG_READ_RECOVERY  = 3'd7;

    // Presence results
    localparam pres_code_t PRES_OK        = 2'd0;
    localparam pres_code_t PRES_NO_ANSWER = 2'd1;
    localparam pres_code_t PRES_STUCK_LOW = 2'd2;

    // Sensor status
    localparam status_t STATUS_NORMAL     = 2'd0;
    localparam status_t STATUS_HIGH_FAULT = 2'd1;
    localparam status_t STATUS_LOW_FAULT  = 2'd2;

    // Sequencer states
    localparam seq_state_t S_IDLE      = 4'd0;
    localparam seq_state_t S_RST_LOW   = 4'd1;
    localparam seq_state_t S_RST_WAIT  = 4'd2;
    localparam seq_state_t S_PRES_WIN  = 4'd3;
    localparam seq_state_t S_PRES_LOW  = 4'd4;
    localparam seq_state_t S_PRES_TAIL = 4'd5;
    localparam seq_state_t S_W_LOW     = 4'd6;
    localparam seq_state_t S_W_REC     = 4'd7;
    localparam seq_state_t S_R_LOW     = 4'd8;
    localparam seq_state_t S_R_WAIT    = 4'd9;
    localparam seq_state_t S_R_REC     = 4'd10;

endpackage

// File: sv/otsp_if.sv
// Handshake channel interfaces of the sensor poller: ticks, results and configuration.
interface otsp_tick_if;
    logic valid;
    logic ready;
    logic action;
    logic line_in;

    modport source (output valid, output action, output line_in, input ready);
    modport sink (input valid, input action, input line_in, output ready);
endinterface

interface otsp_res_if;
    import otsp_pkg::*;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       presence_valid;
    pres_code_t presence_code;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [3:0] rx_index;
    logic       rx_last;
    status_t    sensor_status;
    logic       fault_event;

    modport source (output valid, output drive_low, output busy_res, output presence_valid,
                    output presence_code, output rx_valid, output rx_byte, output rx_index,
                    output rx_last, output sensor_status, output fault_event, input ready);
    modport sink (input valid, input drive_low, input busy_res, input presence_valid,
                  input presence_code, input rx_valid, input rx_byte, input rx_index,
                  input rx_last, input sensor_status, input fault_event, output ready);
endinterface

interface otsp_cfg_if;
    import otsp_pkg::*;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    ticks_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/one_wire_temp_sensor_poller.sv
// 1-Wire master that polls one temperature sensor, one bus tick per request.
//
//  Channel | Direction | Carries
//  --------+-----------+-----------------------------------------------------
//  cfg     | in        | register index and 16-bit timing value
//  tick    | in        | action (start a poll step), line_in (bus sample)
//  res     | out       | drive_low, busy, presence, received byte, status
//
// Each tick request yields one result request; a tick is taken every cycle unless a
// result waits untaken; the state registers feed the result register combinationally.
// The result register stands between the sides: a new tick is taken while the
// previous result is still waiting, as long as the result is taken in that cycle.
// Reset clears the sequencer, fault counters and status, and loads the default timings.
// Configuration writes are taken at any time and are registered into the timing registers.
`include "assert_macros.svh"

module one_wire_temp_sensor_poller (
    input  logic        clk,
    input  logic        rst_n,
    otsp_cfg_if.sink    cfg,
    otsp_tick_if.sink   tick,
    otsp_res_if.source  res
);
    import otsp_pkg::*;

    // Timing registers
    ticks_t reset_low_reg, pres_delay_reg, pres_win_reg, pres_max_reg;
    ticks_t slot_short_reg, slot_long_reg, read_low_reg, read_rec_reg;

    // Sequencer state
    seq_state_t state_reg, state_next;
    ticks_t     timer_reg, timer_next;
    logic [2:0] bit_reg, bit_next;
    logic [3:0] byte_reg, byte_next;
    logic [7:0] shift_reg, shift_next;
    logic       phase_reg, phase_next;
    logic [3:0] high_cnt_reg, high_cnt_next;
    logic [3:0] low_cnt_reg, low_cnt_next;
    status_t    status_reg, status_next;

    // Result register
    logic       res_valid_reg;
    logic       drive_reg, busy_reg, pvalid_reg, rvalid_reg, rlast_reg, event_reg;
    pres_code_t pcode_reg;
    logic [7:0] rbyte_reg;
    logic [3:0] rindex_reg;
    status_t    rstatus_reg;

    // Combinational step
    seq_state_t cur;
    ticks_t     tmr, tinc, phase_len;
    logic       done, finish, pres_hit;
    logic       drive, busy, rvalid, rlast, fault_event;
    pres_code_t pcode;
    logic [7:0] rbyte;
    logic [3:0] rindex;
    logic       accept;

    assign tick.ready = !res_valid_reg || res.ready;
    assign accept     = tick.valid && tick.ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        cur = state_reg;
        tmr = timer_reg;
        if (state_reg == S_IDLE && tick.action)
        begin
            cur = S_RST_LOW;
            tmr = '0;
        end
        busy = (cur != S_IDLE);
        tinc = tmr + 16'd1;

        case (cur)
            S_RST_LOW:   phase_len = reset_low_reg;
            S_RST_WAIT:  phase_len = pres_delay_reg;
            S_PRES_WIN:  phase_len = pres_win_reg;
            S_PRES_LOW:  phase_len = pres_max_reg;
            S_PRES_TAIL: phase_len = pres_delay_reg;
            S_W_LOW:     phase_len = shift_reg[0] ? slot_short_reg : slot_long_reg;
            S_W_REC:     phase_len = shift_reg[0] ? slot_long_reg : slot_short_reg;
            S_R_LOW:     phase_len = read_low_reg;
            S_R_WAIT:    phase_len = slot_short_reg;
            S_R_REC:     phase_len = read_rec_reg;
            default:     phase_len = '1;
        endcase
        // A count of zero ends the phase after one tick, as does a count of one.
        done = (tinc >= phase_len);

        state_next = cur;
        timer_next = tmr;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        finish     = 1'b0;
        pres_hit   = 1'b0;
        pcode      = PRES_OK;
        drive      = 1'b0;
        rvalid     = 1'b0;
        rbyte      = '0;
        rindex     = '0;
        rlast      = 1'b0;

        if (cur != S_IDLE)
        begin
            timer_next = done ? '0 : tinc;
        end

        case (cur)
            S_IDLE:
            begin
                timer_next = tmr;
            end
            S_RST_LOW:
            begin
                drive = 1'b1;
                if (done)
                    state_next = S_RST_WAIT;
            end
            S_RST_WAIT:
            begin
                if (done)
                    state_next = S_PRES_WIN;
            end
            S_PRES_WIN:
            begin
                if (!tick.line_in)
                begin
                    state_next = S_PRES_LOW;
                    timer_next = '0;
                end
                else if (done)
                begin
                    pres_hit = 1'b1;
                    pcode    = PRES_NO_ANSWER;
                end
            end
            S_PRES_LOW:
            begin
                if (tick.line_in)
                begin
                    state_next = S_PRES_TAIL;
                    timer_next = '0;
                end
                else if (done)
                begin
                    pres_hit = 1'b1;
                    pcode    = PRES_STUCK_LOW;
                end
            end
            S_PRES_TAIL:
            begin
                if (done)
                begin
                    pres_hit   = 1'b1;
                    pcode      = PRES_OK;
                    shift_next = CMD_SKIP;
                    bit_next   = '0;
                    byte_next  = '0;
                    state_next = S_W_LOW;
                end
            end
            S_W_LOW:
            begin
                drive = 1'b1;
                if (done)
                    state_next = S_W_REC;
            end
            S_W_REC:
            begin
                if (done)
                begin
                    shift_next = {1'b0, shift_reg[7:1]};
                    bit_next   = bit_reg + 3'd1;
                    if (bit_next != 3'd0)
                    begin
                        state_next = S_W_LOW;
                    end
                    else if (byte_reg == 4'd0)
                    begin
                        shift_next = phase_reg ? CMD_READ : CMD_CONVERT;
                        byte_next  = 4'd1;
                        state_next = S_W_LOW;
                    end
                    else if (phase_reg)
                    begin
                        byte_next  = '0;
                        shift_next = '0;
                        state_next = S_R_LOW;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            S_R_LOW:
            begin
                drive = 1'b1;
                if (done)
                    state_next = S_R_WAIT;
            end
            S_R_WAIT:
            begin
                if (done)
                begin
                    // Bits arrive least significant first, so each enters at the top.
                    shift_next = {tick.line_in, shift_reg[7:1]};
                    state_next = S_R_REC;
                end
            end
            S_R_REC:
            begin
                if (done)
                begin
                    bit_next = bit_reg + 3'd1;
                    if (bit_next != 3'd0)
                    begin
                        state_next = S_R_LOW;
                    end
                    else
                    begin
                        rvalid     = 1'b1;
                        rbyte      = shift_reg;
                        rindex     = byte_reg;
                        rlast      = ({1'b0, byte_reg} + 5'd1 >= SCRATCHPAD_BYTES);
                        byte_next  = byte_reg + 4'd1;
                        shift_next = '0;
                        if (rlast)
                            finish = 1'b1;
                        else
                            state_next = S_R_LOW;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                timer_next = tmr;
            end
        endcase

        // Fault counters follow every presence result.
        high_cnt_next = high_cnt_reg;
        low_cnt_next  = low_cnt_reg;
        status_next   = status_reg;
        if (pres_hit)
        begin
            case (pcode)
                PRES_OK:
                begin
                    high_cnt_next = '0;
                    low_cnt_next  = '0;
                    status_next   = STATUS_NORMAL;
                end
                PRES_NO_ANSWER:
                begin
                    if (high_cnt_reg < FAULT_LIMIT)
                    begin
                        high_cnt_next = high_cnt_reg + 4'd1;
                        if (high_cnt_next >= FAULT_LIMIT)
                            status_next = STATUS_HIGH_FAULT;
                    end
                    low_cnt_next = '0;
                end
                default:
                begin
                    if (low_cnt_reg < FAULT_LIMIT)
                    begin
                        low_cnt_next = low_cnt_reg + 4'd1;
                        if (low_cnt_next >= FAULT_LIMIT)
                            status_next = STATUS_LOW_FAULT;
                    end
                    high_cnt_next = '0;
                end
            endcase
            if (pcode != PRES_OK)
                finish = 1'b1;
        end

        if (finish)
        begin
            state_next = S_IDLE;
            timer_next = '0;
        end
        phase_next  = phase_reg ^ finish;
        fault_event = (status_next != STATUS_NORMAL) && (status_reg == STATUS_NORMAL);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_reg  <= 16'd400;
            pres_delay_reg <= 16'd10;
            pres_win_reg   <= 16'd13;
            pres_max_reg   <= 16'd146;
            slot_short_reg <= 16'd6;
            slot_long_reg  <= 16'd60;
            read_low_reg   <= 16'd2;
            read_rec_reg   <= 16'd33;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_RESET_LOW:      reset_low_reg  <= cfg.data;
                REG_PRESENCE_DELAY: pres_delay_reg <= cfg.data;
                REG_PRESENCE_WIN:   pres_win_reg   <= cfg.data;
                REG_PRESENCE_MAX:   pres_max_reg   <= cfg.data;
                REG_SLOT_SHORT:     slot_short_reg <= cfg.data;
                REG_SLOT_LONG:      slot_long_reg  <= cfg.data;
                REG_READ_LOW:       read_low_reg   <= cfg.data;
                REG_READ_RECOVERY:  read_rec_reg   <= cfg.data;
                default:            read_rec_reg   <= read_rec_reg;
            endcase
        end
    end

    // Sequencer and fault state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            timer_reg    <= '0;
            bit_reg      <= '0;
            byte_reg     <= '0;
            shift_reg    <= '0;
            phase_reg    <= 1'b0;
            high_cnt_reg <= '0;
            low_cnt_reg  <= '0;
            status_reg   <= STATUS_NORMAL;
        end
        else if (accept)
        begin
            state_reg    <= state_next;
            timer_reg    <= timer_next;
            bit_reg      <= bit_next;
            byte_reg     <= byte_next;
            shift_reg    <= shift_next;
            phase_reg    <= phase_next;
            high_cnt_reg <= high_cnt_next;
            low_cnt_reg  <= low_cnt_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg   <= drive;
            busy_reg    <= busy;
            pvalid_reg  <= pres_hit;
            pcode_reg   <= pres_hit ? pcode : PRES_OK;
            rvalid_reg  <= rvalid;
            rbyte_reg   <= rbyte;
            rindex_reg  <= rindex;
            rlast_reg   <= rlast;
            rstatus_reg <= status_next;
            event_reg   <= fault_event;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.drive_low      = drive_reg;
    assign res.busy_res       = busy_reg;
    assign res.presence_valid = pvalid_reg;
    assign res.presence_code  = pcode_reg;
    assign res.rx_valid       = rvalid_reg;
    assign res.rx_byte        = rbyte_reg;
    assign res.rx_index       = rindex_reg;
    assign res.rx_last        = rlast_reg;
    assign res.sensor_status  = rstatus_reg;
    assign res.fault_event    = event_reg;

    `OTSP_ASSERT_IMP(a_idle_timer_clear, state_reg == S_IDLE, timer_reg == 16'd0,
        "timer not cleared in idle")
    `OTSP_ASSERT_IMP(a_normal_below_limit, status_reg == STATUS_NORMAL,
        (high_cnt_reg < FAULT_LIMIT) && (low_cnt_reg < FAULT_LIMIT),
        "fault counter at limit while status is normal")
    `OTSP_ASSERT_IMP(a_read_only_in_read_phase,
        (state_reg == S_R_LOW) || (state_reg == S_R_WAIT) || (state_reg == S_R_REC),
        phase_reg, "read slot outside a read step")
    `OTSP_ASSERT_IMP(a_event_with_presence, res_valid_reg && event_reg, pvalid_reg,
        "fault event without a presence result")

endmodule
